// ----- rtl/llmax_pkg.sv -----
// ----------------------------------------------------------------------------
// llmax_pkg
// Shared types, codes and the softplus breakpoint table of the per-example
// maximum logistic loss block.
// ----------------------------------------------------------------------------
package llmax_pkg;

  localparam int MAX_FEATURES_DEF = 64;
  localparam int MAX_EXAMPLES_DEF = 1024;

  // The breakpoint table spans [-16, 16) in Q16.16 with 2^SEG_BITS segments.
  localparam int SEG_BITS       = 6;
  localparam int TABLE_SEGMENTS = 1 << SEG_BITS;
  localparam int SPAN_BITS      = 21;
  localparam int FRAC_BITS      = SPAN_BITS - SEG_BITS;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ELEMENT = 2'd1,
    ACT_READ    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_CUTOFF = 2'd1,
    REG_BIAS   = 2'd2,
    REG_SLOPE  = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_LOSS = 1'b0,
    KIND_READ = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MUL,
    S_ACC,
    S_WAIT,
    S_UPDATE,
    S_READ
  } state_t;

  typedef struct packed {
    logic        [31:0] gain;
    logic signed [21:0] cutoff;
    logic        [30:0] bias;
    logic        [16:0] slope;
  } loss_cfg_t;

  // Softplus at x = -16 + i/2, rounded to Q16.16.
  function automatic logic [31:0] softplus_point(input logic [SEG_BITS:0] i);
    logic [31:0] y;
    case (i)
      7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8: y = 32'd0;
      7'd9:  y = 32'd1;
      7'd10: y = 32'd1;
      7'd11: y = 32'd2;
      7'd12: y = 32'd3;
      7'd13: y = 32'd5;
      7'd14: y = 32'd8;
      7'd15: y = 32'd13;
      7'd16: y = 32'd22;
      7'd17: y = 32'd36;
      7'd18: y = 32'd60;
      7'd19: y = 32'd98;
      7'd20: y = 32'd162;
      7'd21: y = 32'd267;
      7'd22: y = 32'd440;
      7'd23: y = 32'd724;
      7'd24: y = 32'd1189;
      7'd25: y = 32'd1950;
      7'd26: y = 32'd3184;
      7'd27: y = 32'd5170;
      7'd28: y = 32'd8318;
      7'd29: y = 32'd13200;
      7'd30: y = 32'd20530;
      7'd31: y = 32'd31069;
      7'd32: y = 32'd45426;
      7'd33: y = 32'd63837;
      7'd34: y = 32'd86066;
      7'd35: y = 32'd111504;
      7'd36: y = 32'd139390;
      7'd37: y = 32'd169010;
      7'd38: y = 32'd199792;
      7'd39: y = 32'd231326;
      7'd40: y = 32'd263333;
      7'd41: y = 32'd295636;
      7'd42: y = 32'd328120;
      7'd43: y = 32'd360715;
      7'd44: y = 32'd393378;
      7'd45: y = 32'd426082;
      7'd46: y = 32'd458812;
      7'd47: y = 32'd491556;
      7'd48: y = 32'd524310;
      7'd49: y = 32'd557069;
      7'd50: y = 32'd589832;
      7'd51: y = 32'd622597;
      7'd52: y = 32'd655363;
      7'd53: y = 32'd688130;
      7'd54: y = 32'd720897;
      7'd55: y = 32'd753665;
      7'd56: y = 32'd786432;
      7'd57: y = 32'd819200;
      7'd58: y = 32'd851968;
      7'd59: y = 32'd884736;
      7'd60: y = 32'd917504;
      7'd61: y = 32'd950272;
      7'd62: y = 32'd983040;
      7'd63: y = 32'd1015808;
      7'd64: y = 32'd1048576;
      default: y = 32'd1048576;
    endcase
    return y;
  endfunction

endpackage

// ----- rtl/llmax_loss_unit.sv -----
// ----------------------------------------------------------------------------
// llmax_loss_unit
// Three-stage loss pipeline: saturate and scale the sum, classify it against
// the cutoff, then interpolate the softplus table or evaluate the linear tail.
// ----------------------------------------------------------------------------
module llmax_loss_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [63:0]      sum,
  input  llmax_pkg::loss_cfg_t    cfg,
  output logic                    loss_valid,
  output logic [30:0]             loss
);
  import llmax_pkg::*;

  localparam logic signed [48:0] X_LOW  = -(49'sd1 <<< 20);
  localparam logic signed [48:0] X_HIGH = 49'sd1 <<< 20;
  localparam logic [40:0]        D_MAX  = 41'd1 << 40;

  logic               v1;
  logic               v2;
  logic signed [64:0] prod;

  logic               tail;
  logic [31:0]        lo;
  logic [31:0]        diff;
  logic [FRAC_BITS-1:0] fr;
  logic [40:0]        dc;

  logic signed [31:0] sat;
  logic signed [48:0] x;
  logic signed [48:0] cut;
  logic [SPAN_BITS-1:0] off;
  logic [SEG_BITS-1:0]  seg;
  logic [31:0]        hi_c;
  logic [31:0]        lo_c;
  logic [31:0]        diff_c;
  logic [FRAC_BITS-1:0] fr_c;
  logic signed [49:0] d_full;
  logic [40:0]        dc_c;
  logic [46:0]        interp_prod;
  logic [32:0]        interp;
  logic [57:0]        tail_prod;
  logic [42:0]        tail_sum;

  // Stage one: clamp the sum to 32 bits and apply the gain.
  always_comb begin
    if (sum > 64'sd2147483647) begin
      sat = 32'sh7FFFFFFF;
    end else if (sum < -64'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  // Stage two: locate the scaled value in the table or on the tail.
  always_comb begin
    x      = prod[64:16];
    cut    = {{27{cfg.cutoff[21]}}, cfg.cutoff};
    off    = x[SPAN_BITS-1:0] + SPAN_BITS'(1 << 20);
    seg    = off[SPAN_BITS-1:FRAC_BITS];
    lo_c   = softplus_point({1'b0, seg});
    hi_c   = softplus_point({1'b0, seg} + 7'd1);
    diff_c = 32'd0;
    fr_c   = '0;
    if (x < X_LOW) begin
      lo_c = 32'd0;
    end else if (x >= X_HIGH) begin
      lo_c = softplus_point(7'(TABLE_SEGMENTS));
    end else begin
      diff_c = hi_c - lo_c;
      fr_c   = off[FRAC_BITS-1:0];
    end
    d_full = {x[48], x} - {cut[48], cut};
    if (d_full > $signed({9'd0, D_MAX})) begin
      dc_c = D_MAX;
    end else begin
      dc_c = d_full[40:0];
    end
  end

  // Stage three: interpolate or evaluate the saturating tail.
  always_comb begin
    interp_prod = 47'(diff) * 47'(fr);
    interp      = {1'b0, lo} + {1'b0, interp_prod[46:15]};
    tail_prod   = 58'(dc) * 58'(cfg.slope);
    tail_sum    = 43'(tail_prod[57:16]) + 43'(cfg.bias);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      loss_valid <= 1'b0;
    end else begin
      v1         <= start;
      v2         <= v1;
      loss_valid <= v2;
    end
    prod <= 65'(sat) * $signed({1'b0, cfg.gain});
    tail <= x >= cut;
    lo   <= lo_c;
    diff <= diff_c;
    fr   <= fr_c;
    dc   <= dc_c;
    if (tail) begin
      loss <= (tail_sum > 43'h7FFFFFFF) ? 31'h7FFFFFFF : tail_sum[30:0];
    end else begin
      loss <= interp[30:0];
    end
  end

endmodule

// ----- rtl/logistic_loss_max_per_example.sv -----
// ----------------------------------------------------------------------------
// logistic_loss_max_per_example
// Streams candidate feature elements against a stored weight vector, turns
// each finished sum into a softplus or linear-tail loss, and keeps the largest
// loss and its candidate number per example in an on-chip table.
// ----------------------------------------------------------------------------
// A feature element passes the multiply and accumulate states; the last element
// of a candidate goes on through the 3-stage loss unit and the read-modify-write
// of the per-example table. A read replies from the read state; a weight load is
// written while the block stays idle. A clear writes every table entry to zero in
// turn. Reset: synchronous; it runs the same clearing sweep, with busy high.
// Each result shows for one cycle with done; the receiver cannot stall.
module logistic_loss_max_per_example #(
  parameter int MAX_FEATURES = llmax_pkg::MAX_FEATURES_DEF,
  parameter int MAX_EXAMPLES = llmax_pkg::MAX_EXAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [5:0]         weight_index,
  input  logic [9:0]         example_index,
  input  logic signed [31:0] value,
  input  logic signed [31:0] margin,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic               result_kind,
  output logic [30:0]        loss_out,
  output logic [15:0]        winner_number
);
  import llmax_pkg::*;

  localparam int FW = $clog2(MAX_FEATURES > 1 ? MAX_FEATURES : 2);
  localparam int CW = $clog2(MAX_FEATURES + 1);
  localparam int EW = $clog2(MAX_EXAMPLES > 1 ? MAX_EXAMPLES : 2);

  state_t             state;
  state_t             state_next;
  loss_cfg_t          cfg;

  logic [31:0]        weight_mem [MAX_FEATURES];
  logic signed [31:0] w_rdata;
  logic [46:0]        best_mem [MAX_EXAMPLES];
  logic [46:0]        best_rdata;

  logic signed [31:0] it_value;
  logic signed [31:0] it_margin;
  logic               it_last;
  logic               it_first;
  logic               it_in_range;
  logic [EW-1:0]      it_ex;
  logic               it_ex_ok;

  logic [CW-1:0]      element_counter;
  logic signed [63:0] accumulator;
  logic signed [63:0] product;
  logic [15:0]        candidate_counter;
  logic [EW-1:0]      clr_addr;
  logic [30:0]        loss_reg;

  logic               accept;
  logic [31:0]        widx_wide;
  logic [31:0]        ex_wide;
  logic signed [63:0] acc_base;
  logic signed [63:0] acc_new;
  logic               loss_start;
  logic               loss_valid;
  logic [30:0]        loss_value;
  logic               best_we;
  logic [EW-1:0]      best_waddr;
  logic [46:0]        best_wdata;
  logic [EW-1:0]      best_raddr;
  logic               upd;

  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;
  assign widx_wide = 32'(weight_index);
  assign ex_wide   = 32'(example_index);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain   <= 32'd65536;
      cfg.cutoff <= 22'sd327680;
      cfg.bias   <= 31'd328120;
      cfg.slope  <= 17'd65097;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_GAIN:   cfg.gain   <= cfg_data;
        REG_CUTOFF: cfg.cutoff <= cfg_data[21:0];
        REG_BIAS:   cfg.bias   <= cfg_data[30:0];
        REG_SLOPE:  cfg.slope  <= cfg_data[16:0];
        default:    cfg.gain   <= cfg.gain;
      endcase
    end
  end

  // Weight memory: written on a load transfer, read at the element counter.
  always_ff @(posedge clk) begin
    if (accept && action_t'(action) == ACT_LOAD && widx_wide < 32'(MAX_FEATURES)) begin
      weight_mem[widx_wide[FW-1:0]] <= value;
    end
    w_rdata <= weight_mem[FW'(element_counter)];
  end

  // Per-example table: loss in the upper bits, candidate number below.
  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    best_rdata <= best_mem[best_raddr];
  end

  // Accumulate step and table update decision.
  always_comb begin
    acc_base   = it_first ? 64'(it_margin) : accumulator;
    acc_new    = acc_base - (it_in_range ? (product >>> 16) : 64'sd0);
    loss_start = state == S_ACC && it_last;
    best_raddr = (state == S_IDLE) ? ex_wide[EW-1:0] : it_ex;
    upd        = it_ex_ok && (loss_reg >= best_rdata[46:16]);
    best_we    = 1'b0;
    best_waddr = clr_addr;
    best_wdata = '0;
    if (state == S_CLEAR) begin
      best_we = 1'b1;
    end else if (state == S_UPDATE && upd) begin
      best_we    = 1'b1;
      best_waddr = it_ex;
      best_wdata = {loss_reg, candidate_counter};
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_ELEMENT: state_next = S_MUL;
            ACT_READ:    state_next = S_READ;
            ACT_CLEAR:   state_next = S_CLEAR;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_addr == EW'(MAX_EXAMPLES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = it_last ? S_WAIT : S_IDLE;
      S_WAIT:   state_next = loss_valid ? S_UPDATE : S_WAIT;
      S_UPDATE: state_next = S_IDLE;
      S_READ:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clr_addr          <= '0;
      element_counter   <= '0;
      accumulator       <= '0;
      candidate_counter <= '0;
      done              <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_UPDATE || state == S_READ;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + EW'(1);
      end
      if (accept && action_t'(action) == ACT_CLEAR) begin
        clr_addr          <= '0;
        element_counter   <= '0;
        accumulator       <= '0;
        candidate_counter <= '0;
      end
      if (state == S_ACC) begin
        if (it_last) begin
          element_counter   <= '0;
          accumulator       <= '0;
          candidate_counter <= candidate_counter + 16'd1;
        end else begin
          accumulator     <= acc_new;
          element_counter <= element_counter + CW'(it_in_range);
        end
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_value    <= value;
      it_margin   <= margin;
      it_last     <= last;
      it_first    <= element_counter == '0;
      it_in_range <= element_counter < CW'(MAX_FEATURES);
      it_ex       <= ex_wide[EW-1:0];
      it_ex_ok    <= ex_wide < 32'(MAX_EXAMPLES);
    end
    if (state == S_MUL) begin
      product <= w_rdata * it_value;
    end
    if (loss_valid) begin
      loss_reg <= loss_value;
    end
    if (state == S_UPDATE) begin
      result_kind   <= KIND_LOSS;
      loss_out      <= loss_reg;
      winner_number <= !it_ex_ok ? 16'd0 : (upd ? candidate_counter : best_rdata[15:0]);
    end else if (state == S_READ) begin
      result_kind   <= KIND_READ;
      loss_out      <= it_ex_ok ? best_rdata[46:16] : 31'd0;
      winner_number <= it_ex_ok ? best_rdata[15:0] : 16'd0;
    end
  end

  llmax_loss_unit u_loss (
    .clk        (clk),
    .rst        (rst),
    .start      (loss_start),
    .sum        (acc_new),
    .cfg        (cfg),
    .loss_valid (loss_valid),
    .loss       (loss_value)
  );

  // A result follows only an update or a read reply.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_UPDATE || $past(state) == S_READ)
    else $error("result strobe without a finished transfer");

  // The table is written only by the sweep or by an update.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    best_we |-> state == S_CLEAR || state == S_UPDATE)
    else $error("unexpected table write");

  // The loss unit answers only while the candidate waits for it.
  a_loss_wait: assert property (@(posedge clk) disable iff (rst)
    loss_valid |-> state == S_WAIT)
    else $error("loss result outside the wait state");

  // The element counter never passes the weight vector length.
  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    element_counter <= CW'(MAX_FEATURES))
    else $error("element counter out of range");

endmodule
